// ===== sv/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// types and constants shared by the transfer sequencer files
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  typedef enum logic [1:0] {
    KindLoad  = 2'd0,
    KindStart = 2'd1,
    KindEvent = 2'd2,
    KindNop   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EvModeSelect   = 3'd0,
    EvTxSelected   = 3'd1,
    EvTransmitting = 3'd2,
    EvTransmitted  = 3'd3,
    EvAddr10       = 3'd4,
    EvReceived     = 3'd5,
    EvRxSelected   = 3'd6,
    EvOther        = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    DirTx    = 2'd0,
    DirRx    = 2'd1,
    DirTxReg = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    AckKeep    = 2'd0,
    AckEnable  = 2'd1,
    AckDisable = 2'd2
  } ack_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] tx_slot;
    logic [7:0] tx_value;
    logic [7:0] target_address;
    logic       register_read;
    logic [4:0] tx_count;
    logic [7:0] rx_count;
    logic [2:0] event_code;
    logic [7:0] bus_byte;
  } item_t;

  typedef struct packed {
    logic       send_address;
    logic       address_read;
    logic       send_byte;
    logic [7:0] byte_out;
    logic       make_start;
    logic       make_stop;
    logic [1:0] ack_control;
    logic       store_received;
    logic [7:0] rx_position;
    logic [7:0] rx_value;
    logic       busy_res;
    logic       status;
  } result_t;

  typedef struct packed {
    dir_e       dir;
    logic       busy;
    logic [7:0] slave_address;
    logic [4:0] tx_length;
    logic [4:0] tx_index;
    logic [7:0] rx_length;
    logic [7:0] rx_index;
  } seq_state_t;

  localparam seq_state_t StateReset = '{
    dir:           DirTx,
    busy:          1'b0,
    slave_address: 8'd0,
    tx_length:     5'd0,
    tx_index:      5'd0,
    rx_length:     8'd0,
    rx_index:      8'd0
  };

endpackage

`default_nettype wire

// ===== sv/i2cms_in_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_in_if
// input item channel: loads, starts and bus events
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] tx_slot;
  logic [7:0] tx_value;
  logic [7:0] target_address;
  logic       register_read;
  logic [4:0] tx_count;
  logic [7:0] rx_count;
  logic [2:0] event_code;
  logic [7:0] bus_byte;

  modport source (
    output valid, kind, tx_slot, tx_value, target_address, register_read,
           tx_count, rx_count, event_code, bus_byte,
    input  ready
  );

  modport sink (
    input  valid, kind, tx_slot, tx_value, target_address, register_read,
           tx_count, rx_count, event_code, bus_byte,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/i2cms_out_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_out_if
// result item channel: bus commands and received bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       send_address;
  logic       address_read;
  logic       send_byte;
  logic [7:0] byte_out;
  logic       make_start;
  logic       make_stop;
  logic [1:0] ack_control;
  logic       store_received;
  logic [7:0] rx_position;
  logic [7:0] rx_value;
  logic       busy_res;
  logic       status;

  modport source (
    output valid, send_address, address_read, send_byte, byte_out, make_start,
           make_stop, ack_control, store_received, rx_position, rx_value,
           busy_res, status,
    input  ready
  );

  modport sink (
    input  valid, send_address, address_read, send_byte, byte_out, make_start,
           make_stop, ack_control, store_received, rx_position, rx_value,
           busy_res, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/i2cms_step.sv =====
// ----------------------------------------------------------------------------
// i2cms_step
// next-state and bus command logic for one item
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_step import i2cms_pkg::*; #(
  parameter int TX_DEPTH = 16
) (
  input  item_t      item_i,
  input  seq_state_t state_i,
  input  logic [7:0] tx_byte_i,
  output seq_state_t state_o,
  output result_t    result_o,
  output logic       tx_we_o
);

  logic [7:0] rx_idx_inc;
  logic [8:0] rx_idx_next;

  assign rx_idx_inc  = state_i.rx_index + 8'd1;
  assign rx_idx_next = {1'b0, rx_idx_inc} + 9'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    tx_we_o  = 1'b0;
    case (item_i.kind)
      KindLoad: begin
        if (state_i.busy) begin
          result_o.status = 1'b1;
        end else if (32'(item_i.tx_slot) < 32'(TX_DEPTH)) begin
          tx_we_o = 1'b1;
        end
      end
      KindStart: begin
        if (state_i.busy) begin
          result_o.status = 1'b1;
        end else begin
          state_o.slave_address = item_i.target_address;
          state_o.dir           = item_i.register_read ? DirTxReg : DirTx;
          state_o.tx_length     = (32'(item_i.tx_count) > 32'(TX_DEPTH))
                                  ? 5'(TX_DEPTH) : item_i.tx_count;
          state_o.tx_index      = 5'd0;
          state_o.rx_length     = item_i.register_read ? item_i.rx_count : 8'd0;
          state_o.rx_index      = 8'd0;
          state_o.busy          = 1'b1;
          result_o.ack_control  = AckEnable;
          result_o.make_start   = 1'b1;
        end
      end
      KindEvent: begin
        if (state_i.busy) begin
          case (item_i.event_code)
            EvModeSelect: begin
              result_o.send_address = 1'b1;
              result_o.address_read = (state_i.dir == DirRx);
              if (state_i.tx_length == 5'd0) begin
                result_o.ack_control = AckDisable;
                result_o.make_stop   = 1'b1;
                if (state_i.dir != DirRx) begin
                  state_o.busy = 1'b0;
                end
              end
            end
            EvTransmitting: begin
              if (state_i.tx_index < state_i.tx_length &&
                  32'(state_i.tx_index) < 32'(TX_DEPTH)) begin
                result_o.send_byte = 1'b1;
                result_o.byte_out  = tx_byte_i;
                state_o.tx_index   = state_i.tx_index + 5'd1;
              end else if (state_i.dir == DirTx) begin
                result_o.make_stop = 1'b1;
                state_o.busy       = 1'b0;
              end else if (state_i.dir == DirTxReg) begin
                state_o.dir         = DirRx;
                result_o.make_start = 1'b1;
              end
            end
            EvReceived: begin
              result_o.store_received = 1'b1;
              result_o.rx_position    = state_i.rx_index;
              result_o.rx_value       = item_i.bus_byte;
              state_o.rx_index        = rx_idx_inc;
              if (state_i.rx_length != 8'd0 &&
                  rx_idx_next == {1'b0, state_i.rx_length}) begin
                result_o.ack_control = AckDisable;
                result_o.make_stop   = 1'b1;
              end
              if (rx_idx_inc == state_i.rx_length) begin
                state_o.busy = 1'b0;
              end
            end
            EvRxSelected: begin
              if (state_i.rx_length == 8'd1) begin
                result_o.ack_control = AckDisable;
                result_o.make_stop   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    result_o.busy_res = state_o.busy;
  end

endmodule

`default_nettype wire

// ===== sv/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// i2c master write / register read sequencer driven by decoded bus events
// ----------------------------------------------------------------------------
// an accepted item goes through the input register, then the result register
// throughput: one item per cycle unless out_o.ready stalls the result register;
//   limited by the single step-stage state update; tx read registered from state_d
// reset: asynchronous, clears direction, busy, lengths and indexes; the tx
//   buffer is not cleared and holds undefined data until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer import i2cms_pkg::*; #(
  parameter int TX_DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  i2cms_in_if.sink    in_i,
  i2cms_out_if.source out_o
);

  localparam int TxIdxW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  item_t      item_q;
  logic       item_vld_q;
  seq_state_t state_q;
  seq_state_t step_state;
  seq_state_t state_d;
  result_t    step_result;
  result_t    result_q;
  logic       out_vld_q;
  logic       step_we;
  logic       advance;
  logic [7:0] tx_rd_q;
  logic [7:0] tx_mem [TX_DEPTH];
  item_t      in_item;

  assign in_item = '{
    kind:           in_i.kind,
    tx_slot:        in_i.tx_slot,
    tx_value:       in_i.tx_value,
    target_address: in_i.target_address,
    register_read:  in_i.register_read,
    tx_count:       in_i.tx_count,
    rx_count:       in_i.rx_count,
    event_code:     in_i.event_code,
    bus_byte:       in_i.bus_byte
  };

  assign advance    = item_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;

  i2cms_step #(
    .TX_DEPTH(TX_DEPTH)
  ) u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .tx_byte_i(tx_rd_q),
    .state_o  (step_state),
    .result_o (step_result),
    .tx_we_o  (step_we)
  );

  assign state_d = advance ? step_state : state_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= in_item;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else begin
      state_q <= state_d;
    end
  end

  // tx buffer, read port follows the next tx index
  always_ff @(posedge clk_i) begin
    if (advance && step_we) begin
      tx_mem[TxIdxW'(item_q.tx_slot)] <= item_q.tx_value;
    end
    tx_rd_q <= tx_mem[TxIdxW'(state_d.tx_index)];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.send_address   = result_q.send_address;
  assign out_o.address_read   = result_q.address_read;
  assign out_o.send_byte      = result_q.send_byte;
  assign out_o.byte_out       = result_q.byte_out;
  assign out_o.make_start     = result_q.make_start;
  assign out_o.make_stop      = result_q.make_stop;
  assign out_o.ack_control    = result_q.ack_control;
  assign out_o.store_received = result_q.store_received;
  assign out_o.rx_position    = result_q.rx_position;
  assign out_o.rx_value       = result_q.rx_value;
  assign out_o.busy_res       = result_q.busy_res;
  assign out_o.status         = result_q.status;

endmodule

`default_nettype wire
